// ----- hw/rtl/gto_pkg.sv -----
// Shared types and constants for the graph traversal order core.
// No dependencies; imported by every module of the core.
package gto_pkg;

  localparam int unsigned Vertices   = 8;
  localparam int unsigned VtxW       = 3;
  localparam int unsigned PendDepth  = 64;
  localparam int unsigned PendAw     = $clog2(PendDepth);
  localparam int unsigned CntW       = $clog2(PendDepth + 1);
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 8;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpAdd   = 2'd1,
    OpRun   = 2'd2,
    OpRsvd  = 2'd3
  } opcode_e;

  typedef enum logic {
    OrderBfs = 1'b0,
    OrderDfs = 1'b1
  } order_e;

  typedef struct packed {
    logic            clr;
    logic            add;
    logic [VtxW-1:0] a;
    logic [VtxW-1:0] b;
  } adj_cmd_t;

  typedef struct packed {
    logic            load;
    logic [VtxW-1:0] vtx;
    logic            last;
  } emit_t;

  typedef struct packed {
    logic busy;
    logic held_valid;
  } seq_status_t;

endpackage

// ----- hw/rtl/gto_adj_store.sv -----
// Adjacency bit matrix: one row of flops per vertex, cleared at reset and on a clear transfer.
// Depends on gto_pkg.
module gto_adj_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gto_pkg::adj_cmd_t             cmd_i,
  input  logic [gto_pkg::VtxW-1:0]      row_sel_i,
  output logic [gto_pkg::Vertices-1:0]  row_o
);
  import gto_pkg::*;

  logic [Vertices-1:0] rows_q [Vertices];
  logic [Vertices-1:0] rows_d [Vertices];
  logic                in_range;

  assign in_range = (int'(cmd_i.a) < int'(Vertices)) && (int'(cmd_i.b) < int'(Vertices));

  always_comb begin
    for (int r = 0; r < int'(Vertices); r++) begin
      rows_d[r] = rows_q[r];
      if (cmd_i.clr) begin
        rows_d[r] = '0;
      end else if (cmd_i.add && in_range) begin
        if (r == int'(cmd_i.a)) rows_d[r][cmd_i.b] = 1'b1;
        if (r == int'(cmd_i.b)) rows_d[r][cmd_i.a] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < int'(Vertices); r++) rows_q[r] <= '0;
    end else begin
      for (int r = 0; r < int'(Vertices); r++) rows_q[r] <= rows_d[r];
    end
  end

  assign row_o = rows_q[row_sel_i];

endmodule

// ----- hw/rtl/gto_seq.sv -----
// Traversal sequencer: visited marks, queue/stack memory and a one-neighbour-per-cycle scan.
// Holds back each emitted vertex by one so the final one can carry the last flag. Uses gto_pkg.
module gto_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          order_i,
  input  logic [gto_pkg::Vertices-1:0]  row_i,
  input  logic                          out_free_i,
  output logic [gto_pkg::VtxW-1:0]      row_sel_o,
  output gto_pkg::emit_t                emit_o,
  output gto_pkg::seq_status_t          status_o
);
  import gto_pkg::*;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StStart  = 7'b0000010,
    StPop    = 7'b0000100,
    StCheck  = 7'b0001000,
    StEmit   = 7'b0010000,
    StScan   = 7'b0100000,
    StFinish = 7'b1000000
  } state_e;

  localparam logic [VtxW-1:0] LastVtx = VtxW'(Vertices - 1);

  state_e              state_q, state_d;
  logic [Vertices-1:0] visited_q, visited_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [PendAw-1:0]   head_q, head_d;
  logic [VtxW-1:0]     start_q, start_d;
  logic [VtxW-1:0]     cur_q, cur_d;
  logic [VtxW-1:0]     j_q, j_d;
  logic [VtxW-1:0]     held_q, held_d;
  logic                held_valid_q, held_valid_d;

  logic [VtxW-1:0]     mem [PendDepth];
  logic [VtxW-1:0]     rd_q;
  logic                we;
  logic [PendAw-1:0]   waddr, raddr;
  logic [VtxW-1:0]     wdata;
  logic                push_req;
  logic [VtxW-1:0]     push_vtx;
  logic [CntW-1:0]     count_m1;
  logic                dfs;

  assign dfs      = (order_i == OrderDfs);
  assign count_m1 = count_q - CntW'(1);

  always_comb begin
    state_d      = state_q;
    visited_d    = visited_q;
    count_d      = count_q;
    head_d       = head_q;
    start_d      = start_q;
    cur_d        = cur_q;
    j_d          = j_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    raddr        = head_q;
    push_req     = 1'b0;
    push_vtx     = start_q;
    emit_o       = '0;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          visited_d = '0;
          count_d   = '0;
          head_d    = '0;
          start_d   = '0;
          state_d   = StStart;
        end
      end
      StStart: begin
        if (visited_q[start_q]) begin
          if (start_q == LastVtx) state_d = StFinish;
          else start_d = start_q + VtxW'(1);
        end else begin
          if (!dfs) visited_d[start_q] = 1'b1;
          push_req = 1'b1;
          push_vtx = start_q;
          state_d  = StPop;
        end
      end
      StPop: begin
        if (count_q == '0) begin
          if (start_q == LastVtx) begin
            state_d = StFinish;
          end else begin
            start_d = start_q + VtxW'(1);
            state_d = StStart;
          end
        end else begin
          count_d = count_m1;
          if (dfs) begin
            raddr = head_q + count_m1[PendAw-1:0];
          end else begin
            raddr  = head_q;
            head_d = head_q + PendAw'(1);
          end
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (dfs && visited_q[rd_q]) begin
          state_d = StPop;
        end else begin
          if (dfs) visited_d[rd_q] = 1'b1;
          cur_d   = rd_q;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!held_valid_q || out_free_i) begin
          emit_o.load  = held_valid_q;
          emit_o.vtx   = held_q;
          emit_o.last  = 1'b0;
          held_d       = cur_q;
          held_valid_d = 1'b1;
          j_d          = dfs ? LastVtx : '0;
          state_d      = StScan;
        end
      end
      StScan: begin
        if (row_i[j_q] && !visited_q[j_q]) begin
          push_req = 1'b1;
          push_vtx = j_q;
          if (!dfs) visited_d[j_q] = 1'b1;
        end
        if (dfs ? (j_q == '0) : (j_q == LastVtx)) state_d = StPop;
        else j_d = dfs ? (j_q - VtxW'(1)) : (j_q + VtxW'(1));
      end
      StFinish: begin
        if (!held_valid_q) begin
          state_d = StIdle;
        end else if (out_free_i) begin
          emit_o.load  = 1'b1;
          emit_o.vtx   = held_q;
          emit_o.last  = 1'b1;
          held_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    // push is dropped when the pending store is full
    we    = push_req && (count_q < CntW'(PendDepth));
    waddr = head_q + count_q[PendAw-1:0];
    wdata = push_vtx;
    if (we) count_d = count_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      visited_q    <= '0;
      count_q      <= '0;
      head_q       <= '0;
      start_q      <= '0;
      held_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      visited_q    <= visited_d;
      count_q      <= count_d;
      head_q       <= head_d;
      start_q      <= start_d;
      held_valid_q <= held_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    j_q    <= j_d;
    held_q <= held_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  assign row_sel_o           = cur_q;
  assign status_o.busy       = (state_q != StIdle);
  assign status_o.held_valid = held_valid_q;

endmodule

// ----- hw/rtl/graph_traversal_order_core.sv -----
// Graph traversal order core: clear and add-edge transfers update the adjacency matrix.
// A run is paced by the sequencer scanning one adjacency bit per cycle while the output
// register has room; s_axis_tready stays low meanwhile.
// Results leave through a one-entry output register; output stalls stretch the run.
// Reset (rst_ni, async, active low) clears the matrix, the order register and all control;
// the queue/stack memory is not cleared and needs no clearing pass.
module graph_traversal_order_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] opcode, [4:2] first_vertex, [7:5] second_vertex
  input  logic [gto_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] visited_vertex, [7:3] zero
  output logic [gto_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i
);
  import gto_pkg::*;

  logic                order_q;
  logic                in_xfer;
  opcode_e             opcode;
  adj_cmd_t            adj_cmd;
  logic [Vertices-1:0] row;
  logic [VtxW-1:0]     row_sel;
  emit_t               emit;
  seq_status_t         status;
  logic                run_start;
  logic                out_valid_q;
  logic [VtxW-1:0]     out_vtx_q;
  logic                out_last_q;
  logic                out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !status.busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign opcode        = opcode_e'(s_axis_tdata[1:0]);

  always_comb begin
    adj_cmd   = '0;
    adj_cmd.a = s_axis_tdata[4:2];
    adj_cmd.b = s_axis_tdata[7:5];
    run_start = 1'b0;
    if (in_xfer) begin
      case (opcode)
        OpClear: adj_cmd.clr = 1'b1;
        OpAdd:   adj_cmd.add = 1'b1;
        OpRun:   run_start   = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderBfs;
    end else if (cfg_valid_i && cfg_ready_o) begin
      order_q <= cfg_data_i;
    end
  end

  gto_adj_store u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (adj_cmd),
    .row_sel_i (row_sel),
    .row_o     (row)
  );

  gto_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (run_start),
    .order_i    (order_q),
    .row_i      (row),
    .out_free_i (out_free),
    .row_sel_o  (row_sel),
    .emit_o     (emit),
    .status_o   (status)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_vtx_q  <= emit.vtx;
      out_last_q <= emit.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - VtxW){1'b0}}, out_vtx_q};
  assign m_axis_tlast  = out_last_q;

  // result register is only loaded when free or being drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.load |-> out_free)
    else $error("output register overwritten");

  // no vertex left behind once the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !status.held_valid)
    else $error("held vertex not flushed");

  // a run transfer makes the core busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_start |=> !s_axis_tready)
    else $error("run did not start");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for graph_traversal_order_core: directed table, then random
// edge/traversal streams in both orders, checked against an in-bench traversal predictor.
// Depends on gto_pkg and graph_traversal_order_core only.
`timescale 1ns / 100ps

module tb_top;
  import gto_pkg::*;

  localparam int StallLimit  = 3000;
  localparam int DrainCycles = 200;
  localparam int HoldCycles  = 400;
  localparam int PhaseItems  = 100;
  // nibble i holds the i-th vertex visited
  localparam logic [31:0] InOrder = 32'h7654_3210;

  typedef struct packed {
    logic [VtxW-1:0] vtx;
    logic            last;
  } visit_t;

  typedef struct packed {
    opcode_e         op;
    logic [VtxW-1:0] a;
    logic [VtxW-1:0] b;
    order_e          ord;
    logic            typed;
    logic [31:0]     seq;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_data_i    = 1'b0;

  logic [Vertices-1:0] adj_rows [Vertices] = '{default: '0};
  order_e              cur_order = OrderBfs;
  visit_t              visit_order_q [$];

  int  errors = 0;
  int  results_checked = 0;
  int  items_sent = 0;
  int  clears_sent = 0;
  int  edges_sent = 0;
  int  runs_sent = 0;
  int  ignored_sent = 0;
  int  order_writes = 0;
  int  idle_cycles = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  hold_done = 1'b0;

  dir_row_t dir_rows [25] = '{
    '{OpRun,   3'd0, 3'd0, OrderBfs, 1'b1, InOrder},
    '{OpRsvd,  3'd7, 3'd7, OrderBfs, 1'b0, 32'h0},
    '{OpAdd,   3'd0, 3'd7, OrderBfs, 1'b0, 32'h0},
    '{OpAdd,   3'd7, 3'd7, OrderBfs, 1'b0, 32'h0},
    '{OpAdd,   3'd3, 3'd3, OrderBfs, 1'b0, 32'h0},
    '{OpAdd,   3'd1, 3'd2, OrderBfs, 1'b0, 32'h0},
    '{OpAdd,   3'd5, 3'd2, OrderBfs, 1'b0, 32'h0},
    '{OpAdd,   3'd6, 3'd5, OrderBfs, 1'b0, 32'h0},
    '{OpAdd,   3'd1, 3'd6, OrderBfs, 1'b0, 32'h0},
    '{OpAdd,   3'd4, 3'd0, OrderBfs, 1'b0, 32'h0},
    '{OpRun,   3'd5, 3'd2, OrderBfs, 1'b0, 32'h0},
    '{OpRun,   3'd0, 3'd0, OrderDfs, 1'b0, 32'h0},
    '{OpRsvd,  3'd0, 3'd0, OrderDfs, 1'b0, 32'h0},
    '{OpClear, 3'd5, 3'd2, OrderDfs, 1'b0, 32'h0},
    '{OpRun,   3'd7, 3'd7, OrderDfs, 1'b1, InOrder},
    '{OpAdd,   3'd7, 3'd6, OrderDfs, 1'b0, 32'h0},
    '{OpAdd,   3'd6, 3'd5, OrderDfs, 1'b0, 32'h0},
    '{OpAdd,   3'd4, 3'd5, OrderDfs, 1'b0, 32'h0},
    '{OpAdd,   3'd3, 3'd4, OrderDfs, 1'b0, 32'h0},
    '{OpAdd,   3'd2, 3'd3, OrderDfs, 1'b0, 32'h0},
    '{OpAdd,   3'd1, 3'd2, OrderDfs, 1'b0, 32'h0},
    '{OpAdd,   3'd0, 3'd1, OrderDfs, 1'b0, 32'h0},
    '{OpRun,   3'd0, 3'd0, OrderDfs, 1'b0, 32'h0},
    '{OpRun,   3'd0, 3'd0, OrderBfs, 1'b0, 32'h0},
    '{OpClear, 3'd7, 3'd7, OrderBfs, 1'b0, 32'h0}
  };

  graph_traversal_order_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Updates the graph copy and queues the visit order a command produces.
  function automatic void predict_graph_cmd(input opcode_e op, input logic [VtxW-1:0] a,
                                            input logic [VtxW-1:0] b);
    logic [Vertices-1:0] seen;
    logic [VtxW-1:0]     pend [PendDepth];
    logic [VtxW-1:0]     emitted [Vertices];
    int                  head;
    int                  cnt;
    int                  n;
    int                  v;
    visit_t              item;
    case (op)
      OpClear: adj_rows = '{default: '0};
      OpAdd: begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
      OpRun: begin
        seen = '0;
        head = 0;
        cnt  = 0;
        n    = 0;
        for (int s = 0; s < Vertices; s++) begin
          if (seen[s]) continue;
          if (cur_order == OrderBfs) begin
            seen[s] = 1'b1;
            pend[(head + cnt) % PendDepth] = VtxW'(s);
            cnt++;
            while (cnt > 0) begin
              v = int'(pend[head]);
              head = (head + 1) % PendDepth;
              cnt--;
              emitted[n] = VtxW'(v);
              n++;
              for (int j = 0; j < Vertices; j++) begin
                if (adj_rows[v][j] && !seen[j]) begin
                  if (cnt < PendDepth) begin
                    pend[(head + cnt) % PendDepth] = VtxW'(j);
                    cnt++;
                  end
                  seen[j] = 1'b1;
                end
              end
            end
          end else begin
            pend[(head + cnt) % PendDepth] = VtxW'(s);
            cnt++;
            while (cnt > 0) begin
              cnt--;
              v = int'(pend[(head + cnt) % PendDepth]);
              if (seen[v]) continue;
              seen[v] = 1'b1;
              emitted[n] = VtxW'(v);
              n++;
              for (int j = Vertices - 1; j >= 0; j--) begin
                if (adj_rows[v][j] && !seen[j] && cnt < PendDepth) begin
                  pend[(head + cnt) % PendDepth] = VtxW'(j);
                  cnt++;
                end
              end
            end
          end
        end
        for (int i = 0; i < n; i++) begin
          item.vtx  = emitted[i];
          item.last = (i == n - 1);
          visit_order_q.push_back(item);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_cmd(input opcode_e op, input logic [VtxW-1:0] a,
                          input logic [VtxW-1:0] b, input logic typed, input logic [31:0] seq);
    int     gap;
    visit_t item;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 24) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {b, a, op};
    s_axis_tvalid <= 1'b1;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    if (typed) begin
      for (int i = 0; i < Vertices; i++) begin
        item.vtx  = seq[4*i +: VtxW];
        item.last = (i == Vertices - 1);
        visit_order_q.push_back(item);
      end
    end else begin
      predict_graph_cmd(op, a, b);
    end
    case (op)
      OpClear: clears_sent++;
      OpAdd:   edges_sent++;
      OpRun:   runs_sent++;
      default: ignored_sent++;
    endcase
    if (op != OpRsvd) items_sent++;
  endtask

  // Order register is only written once the core has gone quiet.
  task automatic set_order(input order_e ord);
    s_axis_tvalid <= 1'b0;
    while (visit_order_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_data_i  <= ord;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_order = ord;
    order_writes++;
  endtask

  initial begin
    int              target;
    logic [VtxW-1:0] a;
    logic [VtxW-1:0] b;
    int              k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_order(OrderBfs);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].ord != cur_order) set_order(dir_rows[i].ord);
      send_cmd(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
               dir_rows[i].seq);
    end

    for (int p = 0; p < 4; p++) begin
      set_order((p % 2 == 0) ? OrderDfs : OrderBfs);
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        a = VtxW'($urandom_range(0, 7));
        b = VtxW'($urandom_range(0, 7));
        if ($urandom_range(0, 2) == 0) send_cmd(OpClear, a, b, 1'b0, 32'h0);
        k = $urandom_range(0, 12);
        repeat (k) begin
          a = VtxW'($urandom_range(0, 7));
          b = VtxW'($urandom_range(0, 7));
          if ($urandom_range(0, 7) == 0) b = a;
          if ($urandom_range(0, 19) == 0) send_cmd(OpRsvd, b, a, 1'b0, 32'h0);
          send_cmd(OpAdd, a, b, 1'b0, 32'h0);
        end
        // occasionally wipe the graph just before traversing it
        if ($urandom_range(0, 9) == 0) send_cmd(OpClear, b, a, 1'b0, 32'h0);
        a = VtxW'($urandom_range(0, 7));
        b = VtxW'($urandom_range(0, 7));
        send_cmd(OpRun, a, b, 1'b0, 32'h0);
        if ($urandom_range(0, 5) == 0) send_cmd(OpRun, b, a, 1'b0, 32'h0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (visit_order_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d clears, %0d edge adds, %0d traversals and %0d unused opcodes",
             clears_sent, edges_sent, runs_sent, ignored_sent);
    $display("Checked %0d visited vertices across %0d order register writes",
             results_checked, order_writes);
    if (errors == 0 && visit_order_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int              gap;
    visit_t          want;
    logic [VtxW-1:0] got_vtx;
    logic            got_last;
    wait (rst_ni);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
      if (!hold_done && results_checked >= 200) begin
        // long back-pressure so the core stalls its input
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      got_vtx  = m_axis_tdata[VtxW-1:0];
      got_last = m_axis_tlast;
      @(posedge clk_i);
      results_checked++;
      if (visit_order_q.size() == 0) begin
        $error("unexpected transfer: visited_vertex %0d last_of_run %0b", got_vtx, got_last);
        errors++;
      end else begin
        want = visit_order_q.pop_front();
        if (got_vtx !== want.vtx) begin
          $error("visited_vertex: expected %0d, got %0d", want.vtx, got_vtx);
          errors++;
        end
        if (got_last !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, got_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 StallLimit, visit_order_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
